FILE: rtl/flash_erase_range_planner_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker of the flash erase range planner.
// Each macro states one clocked property that is ignored while reset is high.
// ---------------------------------------------------------------------------
`ifndef FLASH_ERASE_RANGE_PLANNER_ASSERT_SVH
`define FLASH_ERASE_RANGE_PLANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FERP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FERP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ferp_pkg.sv
// ---------------------------------------------------------------------------
// ferp_pkg
// Types, sizes and command codes shared by the erase range planner modules.
// ---------------------------------------------------------------------------
package ferp_pkg;

  // Flash geometry: byte address width and the width that can hold the size.
  localparam int ADDR_BITS = 20;
  localparam int WIDE_BITS = ADDR_BITS + 1;

  localparam logic [WIDE_BITS-1:0] FLASH_SIZE = WIDE_BITS'(1) << ADDR_BITS;
  localparam logic [WIDE_BITS-1:0] SZ_64K     = WIDE_BITS'(32'h1_0000);
  localparam logic [WIDE_BITS-1:0] SZ_32K     = WIDE_BITS'(32'h8000);
  localparam logic [WIDE_BITS-1:0] SZ_4K      = WIDE_BITS'(32'h1000);

  // Erase command codes.
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_CHIP = 3'd1;
  localparam logic [2:0] KIND_64K  = 3'd2;
  localparam logic [2:0] KIND_32K  = 3'd3;
  localparam logic [2:0] KIND_4K   = 3'd4;

  // One erase request.
  typedef struct packed {
    logic [ADDR_BITS-1:0] start_address;
    logic [WIDE_BITS-1:0] end_address;
  } erase_req_t;

  // One erase command of the run.
  typedef struct packed {
    logic [2:0]           erase_kind;
    logic [ADDR_BITS-1:0] erase_address;
    logic                 last;
  } erase_cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // Status from the datapath: the command for the current position.
  typedef struct packed {
    erase_cmd_t cmd;
  } dp_status_t;

endpackage

FILE: rtl/ferp_dp.sv
// ---------------------------------------------------------------------------
// ferp_dp
// Address datapath: holds the current position and the range end, picks the
// erase size for the position and moves to the next boundary on each step.
// ---------------------------------------------------------------------------
module ferp_dp (
  input  logic                 clk,
  input  ferp_pkg::dp_cmd_t    cmd,
  input  ferp_pkg::erase_req_t req,
  output ferp_pkg::dp_status_t status
);
  import ferp_pkg::*;

  logic [WIDE_BITS-1:0] cur;
  logic [WIDE_BITS-1:0] range_end;
  logic [WIDE_BITS-1:0] cur_next;
  logic [WIDE_BITS-1:0] end_sat;
  logic [WIDE_BITS-1:0] base64;
  logic [WIDE_BITS-1:0] base32;
  logic [WIDE_BITS-1:0] size;
  logic [WIDE_BITS-1:0] bound;
  logic                 empty;
  logic                 hit_chip;
  logic                 hit_64k;
  logic                 hit_32k;
  logic [2:0]           kind;

  // An end beyond the flash is clipped to the flash size.
  assign end_sat = (req.end_address > FLASH_SIZE) ? FLASH_SIZE : req.end_address;

  // Size tests at the current position.
  assign empty    = (cur >= range_end);
  assign base64   = cur & ~(SZ_64K - WIDE_BITS'(1));
  assign base32   = cur & ~(SZ_32K - WIDE_BITS'(1));
  assign hit_chip = (cur < SZ_4K) && (range_end > FLASH_SIZE - SZ_4K);
  assign hit_64k  = ((cur - base64) < SZ_4K) && (range_end > base64 + SZ_64K - SZ_4K);
  assign hit_32k  = ((cur - base32) < SZ_4K) && (range_end > base32 + SZ_32K - SZ_4K);

  // Pick the command and the next position, capped at the range end.
  always_comb begin
    kind = KIND_4K;
    size = SZ_4K;
    if (empty) begin
      kind = KIND_NONE;
    end else if (hit_chip) begin
      kind = KIND_CHIP;
    end else if (hit_64k) begin
      kind = KIND_64K;
      size = SZ_64K;
    end else if (hit_32k) begin
      kind = KIND_32K;
      size = SZ_32K;
    end
    bound = (cur + size) & ~(size - WIDE_BITS'(1));
    if (empty) begin
      cur_next = cur;
    end else if (kind == KIND_CHIP || bound >= range_end) begin
      cur_next = range_end;
    end else begin
      cur_next = bound;
    end
  end

  assign status.cmd.erase_kind    = kind;
  assign status.cmd.erase_address = cur[ADDR_BITS-1:0];
  assign status.cmd.last          = empty || (cur_next >= range_end);

  // Position registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur       <= {1'b0, req.start_address};
      range_end <= end_sat;
    end else if (cmd.step) begin
      cur       <= cur_next;
    end
  end

endmodule

FILE: rtl/ferp_ctrl.sv
// ---------------------------------------------------------------------------
// ferp_ctrl
// Run controller: takes one request, then steps the datapath once per free
// output slot and registers each erase command until the last one.
// ---------------------------------------------------------------------------
module ferp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ferp_pkg::erase_cmd_t out_data,
  output ferp_pkg::dp_cmd_t    cmd,
  input  ferp_pkg::dp_status_t status
);
  import ferp_pkg::*;

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state;
  logic   slot_free;

  // The output register can take a command when empty or being drained.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != IDLE);
  assign cmd.load  = in_valid && (state == IDLE);
  assign cmd.step  = (state == RUN) && slot_free;

  // State and output register. While running, a free slot is refilled at
  // once; while idle, a drained command leaves the register empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
          if (in_valid) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_data  <= status.cmd;
            if (status.cmd.last) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/flash_erase_range_planner.sv
// ---------------------------------------------------------------------------
// flash_erase_range_planner
// Turns an erase request for a byte range of the flash into a run of chip,
// 64 KB, 32 KB and 4 KB erase commands that cover the range.
// ---------------------------------------------------------------------------
//  channel | direction | payload      | handshake
//  in      | input     | erase_req_t  | in_valid / in_stall
//  out     | output    | erase_cmd_t  | out_valid / out_stall
//
// A request is taken while the controller is idle; then one command leaves
// per cycle while the output is not stalled. The rate is set by the single
// address step unit. Reset returns the controller to idle and empties the
// output register. A stalled output holds its command and pauses the run;
// no new request is taken until the last command of the run has been
// registered.
module flash_erase_range_planner (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ferp_pkg::erase_req_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ferp_pkg::erase_cmd_t out_data
);
  import ferp_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencing of the run.
  ferp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

  // Address arithmetic.
  ferp_dp u_dp (
    .clk    (clk),
    .cmd    (dp_cmd),
    .req    (in_data),
    .status (dp_status)
  );

endmodule

FILE: rtl/ferp_checker.sv
// ---------------------------------------------------------------------------
// ferp_checker
// Port-level checks on the erase range planner, bound to the top level.
// ---------------------------------------------------------------------------
`include "flash_erase_range_planner_assert.svh"

module ferp_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input ferp_pkg::erase_req_t in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input ferp_pkg::erase_cmd_t out_data
);
  import ferp_pkg::*;

  // A taken request starts a run, so no second request follows at once.
  `FERP_ASSERT_NEXT(a_busy_after_req, clk, rst, in_valid && !in_stall, in_stall,
                    "request taken while a run starts")

  // While a command other than the last waits at the output, the run is open.
  `FERP_ASSERT_SAME(a_run_open, clk, rst, out_valid && !out_data.last, in_stall,
                    "run closed before its last command")

  // An empty range is answered by a single, final command.
  `FERP_ASSERT_SAME(a_none_is_last, clk, rst, out_valid && out_data.erase_kind == KIND_NONE,
                    out_data.last, "empty-range answer not marked last")

  // A stalled command stays and does not change.
  `FERP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(out_data), "stalled command changed")

endmodule

bind flash_erase_range_planner ferp_checker u_ferp_checker (.*);

FILE: tb/flash_erase_range_planner_tb.sv
// ---------------------------------------------------------------------------
// flash_erase_range_planner_tb
// Sends erase requests for byte ranges of the flash and checks every erase
// command that comes back against a model of the planning rules kept here.
// Directed requests cover empty ranges, chip erases, each block size and
// ranges that run past the flash. About four hundred random requests follow,
// under changing amounts of idling on both sides.
// ---------------------------------------------------------------------------
module flash_erase_range_planner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ferp_pkg::*;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  erase_req_t in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  erase_cmd_t out_data;

  // Commands predicted for requests already taken, oldest first.
  erase_cmd_t pending_cmds[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int n_requests;
  int n_commands = 0;
  int n_errors = 0;
  int kind_count[5] = '{default: 0};

  flash_erase_range_planner dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The run is ended here if it hangs.
  initial begin
    #5_000_000;
    $display("flash_erase_range_planner: mismatch");
    $finish;
  end

  // Random stall on the command output.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  function automatic erase_req_t make_req(input int unsigned s, input int unsigned e);
    erase_req_t r;
    r.start_address = s[ADDR_BITS-1:0];
    r.end_address   = e[WIDE_BITS-1:0];
    return r;
  endfunction

  // Work out the whole run of commands for one request and queue it.
  function automatic void plan_erase(input erase_req_t r);
    int unsigned pos;
    int unsigned stop;
    int unsigned nxt;
    int unsigned size;
    int unsigned flash;
    int unsigned sz4;
    int unsigned sz32;
    int unsigned sz64;
    erase_cmd_t  c;
    flash = int'(FLASH_SIZE);
    sz4   = int'(SZ_4K);
    sz32  = int'(SZ_32K);
    sz64  = int'(SZ_64K);
    pos   = r.start_address;
    stop  = r.end_address;
    if (stop > flash) stop = flash;

    // An empty range gives a single command with nothing to erase.
    if (stop <= pos) begin
      c.erase_kind    = KIND_NONE;
      c.erase_address = pos[ADDR_BITS-1:0];
      c.last          = 1'b1;
      pending_cmds.push_back(c);
      return;
    end

    while (pos < stop) begin
      if (pos < sz4 && stop > flash - sz4) begin
        c.erase_kind = KIND_CHIP;
      end else if ((pos % sz64) < sz4 && stop > (pos & ~(sz64 - 1)) + sz64 - sz4) begin
        c.erase_kind = KIND_64K;
      end else if ((pos % sz32) < sz4 && stop > (pos & ~(sz32 - 1)) + sz32 - sz4) begin
        c.erase_kind = KIND_32K;
      end else begin
        c.erase_kind = KIND_4K;
      end

      // Move to the next boundary of the erased size, never past the end.
      if (c.erase_kind == KIND_CHIP) begin
        nxt = stop;
      end else begin
        size = (c.erase_kind == KIND_64K) ? sz64 : (c.erase_kind == KIND_32K) ? sz32 : sz4;
        nxt  = ((pos + size) & ~(size - 1)) & ((flash << 1) - 1);
        if (nxt > stop) nxt = stop;
      end

      c.erase_address = pos[ADDR_BITS-1:0];
      c.last          = (nxt >= stop);
      pending_cmds.push_back(c);
      pos = nxt;
    end
  endfunction

  // Compare each command taken from the block with the oldest prediction.
  always @(posedge clk) begin
    erase_cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      n_commands++;
      if (out_data.erase_kind <= KIND_4K) kind_count[out_data.erase_kind]++;
      if (pending_cmds.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected command kind %0d addr %h last %b", $time,
                 out_data.erase_kind, out_data.erase_address, out_data.last);
      end else begin
        want = pending_cmds.pop_front();
        if (out_data.erase_kind !== want.erase_kind ||
            out_data.erase_address !== want.erase_address ||
            out_data.last !== want.last) begin
          n_errors++;
          $display("%0t: expected kind %0d addr %h last %b, got kind %0d addr %h last %b",
                   $time, want.erase_kind, want.erase_address, want.last,
                   out_data.erase_kind, out_data.erase_address, out_data.last);
        end
      end
    end
  end

  // Offer one request, with a random gap first, and wait until it is taken.
  // Valid is left high on return so that back-to-back requests need no drop.
  task automatic send_request(input erase_req_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    plan_erase(r);
    n_requests++;
  endtask

  // Hold off new requests until every predicted command has come back.
  task automatic wait_idle(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic test_empty_ranges();
    send_request(make_req(32'h00000, 32'h00000));
    send_request(make_req(32'h12345, 32'h12345));
    send_request(make_req(32'hFFFFF, 32'h00000));
    send_request(make_req(32'h80000, 32'h7FFFF));
  endtask

  task automatic test_chip_erase();
    send_request(make_req(32'h00000, 32'h100000));
    send_request(make_req(32'h00FFF, 32'hFF001));
    send_request(make_req(32'h00010, 32'h1FFFFF));
    // One byte short of the last sector: no chip erase.
    send_request(make_req(32'h00000, 32'hFF000));
  endtask

  task automatic test_block_sizes();
    send_request(make_req(32'h12345, 32'h12346));
    send_request(make_req(32'h20000, 32'h2F001));
    send_request(make_req(32'h20FFF, 32'h2F000));
    send_request(make_req(32'h28000, 32'h2F001));
    send_request(make_req(32'h28FFF, 32'h30000));
    send_request(make_req(32'h01000, 32'h100000));
    send_request(make_req(32'h01001, 32'hFFFFF));
    send_request(make_req(32'h0F001, 32'hF8FFF));
  endtask

  task automatic test_flash_limits();
    send_request(make_req(32'hFFFFF, 32'h100000));
    send_request(make_req(32'hFFFFF, 32'h1FFFFF));
    send_request(make_req(32'h80000, 32'h100001));
    send_request(make_req(32'hAAAAA, 32'h155555));
    send_request(make_req(32'h55555, 32'h0AAAAA));
  endtask

  // Random requests, mostly non-empty ranges with a bias to block edges.
  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    int unsigned s;
    int unsigned e;
    int unsigned a;
    int unsigned b;
    int          pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      s    = $urandom_range(0, 32'hFFFFF);
      if (pick < 30) begin
        e = s + $urandom_range(1, 32'h3000);
      end else if (pick < 55) begin
        a = $urandom_range(0, 32'hFFFFF);
        b = $urandom_range(0, 32'hFFFFF);
        s = (a < b) ? a : b;
        e = ((a < b) ? b : a) + 1;
      end else if (pick < 75) begin
        s = $urandom_range(0, 255) << 12;
        if ($urandom_range(0, 3) == 0) s += $urandom_range(0, 32'hFFF);
        e = (((s >> 12) + $urandom_range(1, 40)) << 12) + $urandom_range(0, 2) - 1;
      end else if (pick < 85) begin
        e = $urandom_range(0, s);
      end else if (pick < 93) begin
        e = $urandom_range(32'h100000, 32'h1FFFFF);
      end else begin
        s = $urandom_range(0, 32'h1FFF);
        e = $urandom_range(32'hFE000, 32'h100000);
      end
      send_request(make_req(s, e));
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    n_requests  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_ranges();
    test_chip_erase();
    test_block_sizes();
    test_flash_limits();
    wait_idle(20000);

    test_random(133, 23, 53);
    wait_idle(20000);
    test_random(133, 53, 23);
    wait_idle(20000);
    test_random(134, 0, 0);
    wait_idle(100000);

    if (pending_cmds.size() != 0) begin
      $display("%0t: %0d predicted commands never arrived", $time, pending_cmds.size());
    end

    $display("Sent %0d erase requests and checked %0d commands.", n_requests, n_commands);
    $display("Commands by kind: none %0d, chip %0d, 64K %0d, 32K %0d, 4K %0d.",
             kind_count[KIND_NONE], kind_count[KIND_CHIP], kind_count[KIND_64K],
             kind_count[KIND_32K], kind_count[KIND_4K]);
    if (n_errors == 0 && pending_cmds.size() == 0) begin
      $display("flash_erase_range_planner: match");
    end else begin
      $display("flash_erase_range_planner: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ferp_pkg.sv
rtl/ferp_dp.sv
rtl/ferp_ctrl.sv
rtl/flash_erase_range_planner.sv
rtl/ferp_checker.sv
tb/flash_erase_range_planner_tb.sv
